@@ src/crtc_pkg.sv @@
// shared constants and types of the coalescing range table checker
package crtc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_WIDTH  = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int FIELD_W     = 64;
   localparam int REQ_DATA_W  = 2 * FIELD_W;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_COUNT_W = 7;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_MERGED  = 2'd1;
   localparam logic [1:0] STAT_DROPPED = 2'd2;

   // query word walking down the chain
   typedef struct packed {
      logic     active;
      logic     hit;
      addr_type base;
      addr_type end_addr;
   } token_type;

   // write broadcast to all cells
   typedef struct packed {
      logic     en;
      logic     set_base;
      idx_type  idx;
      addr_type base;
      addr_type end_addr;
   } cell_wr_type;

endpackage

@@ src/coalescing_range_table_checker.sv @@
// coalescing range table checker top level: control, bounds, cell chain
//
//   channel   dir  handshake             payload
//   req_      in   req_tvalid/req_tready  tuser: req_type; tdata: range_base, range_size
//   rsp_      out  rsp_tvalid/rsp_tready  tdata: contained, status, range_count
//
// the result of a clear or add is registered the next cycle
// a query walks the query word through all TABLE_DEPTH cells, one cell per
// cycle, and its result is registered once the word leaves the last cell
// one item at a time: no new word is taken while a query is in the chain
// reset empties the table; entry contents are not cleared
// the result register holds while rsp_tready is low
module coalescing_range_table_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [crtc_pkg::REQ_DATA_W-1:0]    req_tdata,  // range_base, range_size
   input  logic [1:0]                         req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [crtc_pkg::RSP_DATA_W-1:0]    rsp_tdata   // contained, status, range_count
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   crtc_pkg::cnt_type                 count_ff, count_in;
   crtc_pkg::addr_type                low_ff, low_in;
   crtc_pkg::addr_type                high_ff, high_in;
   logic                              pass_ff, pass_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_contained_ff, rsp_contained_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   crtc_pkg::cnt_type                 rsp_count_ff, rsp_count_in;

   logic                              accept;
   logic                              rsp_free;
   crtc_pkg::addr_type                in_base;
   crtc_pkg::addr_type                in_size;
   crtc_pkg::addr_type                in_end;
   logic                              can_merge;
   crtc_pkg::cell_wr_type             wr;
   crtc_pkg::token_type               chain [crtc_pkg::TABLE_DEPTH+1];

   assign in_base  = req_tdata[crtc_pkg::ADDR_WIDTH-1:0];
   assign in_size  = req_tdata[crtc_pkg::FIELD_W +: crtc_pkg::ADDR_WIDTH];
   assign in_end   = in_base + in_size;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept   = req_tvalid && req_tready;
   assign can_merge = (count_ff != '0) && (in_base == high_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      low_in           = low_ff;
      high_in          = high_ff;
      pass_in          = pass_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_contained_in = rsp_contained_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      wr.en            = 1'b0;
      wr.set_base      = 1'b0;
      wr.idx           = crtc_pkg::IDX_W'(count_ff);
      wr.base          = in_base;
      wr.end_addr      = in_end;
      chain[0].active  = 1'b0;
      chain[0].hit     = 1'b0;
      chain[0].base    = in_base;
      chain[0].end_addr = in_end;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_contained_in = 1'b0;
               rsp_status_in    = crtc_pkg::STAT_DONE;
               rsp_count_in     = count_ff;
               rsp_valid_in     = 1'b1;
               case (req_tuser)
                  crtc_pkg::REQ_CLEAR: begin
                     count_in     = '0;
                     low_in       = '0;
                     high_in      = '0;
                     rsp_count_in = '0;
                  end
                  crtc_pkg::REQ_ADD: begin
                     if (can_merge) begin
                        wr.en         = 1'b1;
                        wr.idx        = crtc_pkg::IDX_W'(count_ff - crtc_pkg::CNT_W'(1));
                        high_in       = in_end;
                        rsp_status_in = crtc_pkg::STAT_MERGED;
                     end else if (count_ff < crtc_pkg::CNT_W'(crtc_pkg::TABLE_DEPTH)) begin
                        wr.en        = 1'b1;
                        wr.set_base  = 1'b1;
                        high_in      = in_end;
                        count_in     = count_ff + crtc_pkg::CNT_W'(1);
                        rsp_count_in = count_ff + crtc_pkg::CNT_W'(1);
                        if (count_ff == '0) begin
                           low_in = in_base;
                        end
                     end else begin
                        rsp_status_in = crtc_pkg::STAT_DROPPED;
                     end
                  end
                  crtc_pkg::REQ_QUERY: begin
                     rsp_valid_in    = rsp_valid_ff && !rsp_tready;
                     chain[0].active = 1'b1;
                     pass_in         = (in_base >= low_ff) && (in_end <= high_ff);
                     state_in        = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (chain[crtc_pkg::TABLE_DEPTH].active) begin
               rsp_valid_in     = 1'b1;
               rsp_contained_in = pass_ff && chain[crtc_pkg::TABLE_DEPTH].hit;
               rsp_status_in    = crtc_pkg::STAT_DONE;
               rsp_count_in     = count_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < crtc_pkg::TABLE_DEPTH; i++) begin : g_cell
      crtc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (crtc_pkg::IDX_W'(i)),
         .count    (count_ff),
         .wr       (wr),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff          <= pass_in;
      rsp_contained_ff <= rsp_contained_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = crtc_pkg::RSP_DATA_W'({crtc_pkg::RSP_COUNT_W'(rsp_count_ff),
                                              rsp_status_ff, rsp_contained_ff});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crtc_pkg::CNT_W'(crtc_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_empty_bounds: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (low_ff == '0 && high_ff == '0))
      else $error("bounds not zero on empty table");

   a_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[crtc_pkg::TABLE_DEPTH].active |-> (state_ff == ST_SCAN))
      else $error("query word left chain outside scan");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chain[crtc_pkg::TABLE_DEPTH].active) |=> rsp_valid_ff)
      else $error("finished query gave no result");

endmodule

@@ src/crtc_cell.sv @@
// one table entry cell: holds base and end, checks the passing query word
module crtc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  crtc_pkg::idx_type     cell_idx,
   input  crtc_pkg::cnt_type     count,
   input  crtc_pkg::cell_wr_type wr,
   input  crtc_pkg::token_type   tok_in,
   output crtc_pkg::token_type   tok_out
);

   crtc_pkg::addr_type  base_ff, base_in;
   crtc_pkg::addr_type  end_ff, end_in;
   crtc_pkg::token_type tok_ff, tok_in_nxt;
   logic                wr_sel;
   logic                occupied;
   logic                match;

   assign wr_sel   = wr.en && (wr.idx == cell_idx);
   assign occupied = crtc_pkg::CNT_W'(cell_idx) < count;
   assign match    = occupied && (tok_in.base >= base_ff) && (tok_in.end_addr <= end_ff);

   always_comb begin
      base_in = base_ff;
      end_in  = end_ff;
      if (wr_sel) begin
         end_in = wr.end_addr;
         if (wr.set_base) begin
            base_in = wr.base;
         end
      end
      tok_in_nxt     = tok_in;
      tok_in_nxt.hit = tok_in.hit || (tok_in.active && match);
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      end_ff   <= end_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

@@ bench/coalescing_range_table_checker_tb.sv @@
// self-checking testbench for the coalescing range table checker
`timescale 1ns / 100ps

module coalescing_range_table_checker_tb;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int N_ITEMS     = 1100;
   localparam int PHASE_LEN   = 128;
   localparam int HOLD_START  = 520;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [1:0]         kind;
      crtc_pkg::addr_type base;
      crtc_pkg::addr_type size;
   } range_req_type;

   typedef struct packed {
      logic [5:0] pad;
      logic [6:0] count;
      logic [1:0] status;
      logic       contained;
   } table_rsp_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [crtc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [crtc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   range_req_type pending_words[$];
   table_rsp_type expected_rsp[$];

   // predicted table contents
   crtc_pkg::addr_type tbl_base [crtc_pkg::TABLE_DEPTH];
   crtc_pkg::addr_type tbl_size [crtc_pkg::TABLE_DEPTH];
   int                 tbl_count = 0;

   // rough view of the table used to aim queries
   crtc_pkg::addr_type gen_lo[$];
   crtc_pkg::addr_type gen_hi[$];
   int                 gen_items = 0;

   int req_count   = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int error_count = 0;
   int n_words     = 0;
   int n_hits      = 0;
   int n_merged    = 0;
   int n_dropped   = 0;
   int n_clears    = 0;

   coalescing_range_table_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic crtc_pkg::addr_type rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit idle_roll(bit rx_side);
      int idle_phase;
      idle_phase = (req_count / PHASE_LEN) % 4;
      case (idle_phase)
         1: return !rx_side && ($urandom_range(0, 99) < 66);
         2: return rx_side && ($urandom_range(0, 99) < 66);
         3: return $urandom_range(0, 99) < 38;
         default: return 1'b0;
      endcase
   endfunction

   function automatic table_rsp_type predict_table(logic [1:0] kind,
                                                   crtc_pkg::addr_type base,
                                                   crtc_pkg::addr_type size);
      table_rsp_type      r;
      crtc_pkg::addr_type q_end;
      crtc_pkg::addr_type last_end;
      r = '0;
      last_end = (tbl_count > 0) ? tbl_base[tbl_count-1] + tbl_size[tbl_count-1] : '0;
      case (kind)
         crtc_pkg::REQ_CLEAR: begin
            tbl_count = 0;
         end
         crtc_pkg::REQ_ADD: begin
            if (tbl_count > 0 && base == last_end) begin
               tbl_size[tbl_count-1] = tbl_size[tbl_count-1] + size;
               r.status = crtc_pkg::STAT_MERGED;
            end else if (tbl_count < crtc_pkg::TABLE_DEPTH) begin
               tbl_base[tbl_count] = base;
               tbl_size[tbl_count] = size;
               tbl_count++;
            end else begin
               r.status = crtc_pkg::STAT_DROPPED;
            end
         end
         crtc_pkg::REQ_QUERY: begin
            q_end = base + size;
            if (tbl_count > 0 && base >= tbl_base[0] && q_end <= last_end) begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (!r.contained && base >= tbl_base[i] &&
                      q_end <= crtc_pkg::addr_type'(tbl_base[i] + tbl_size[i]))
                     r.contained = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.count = tbl_count[6:0];
      return r;
   endfunction

   task automatic push_word(logic [1:0] kind, crtc_pkg::addr_type base,
                            crtc_pkg::addr_type size);
      pending_words.push_back('{kind, base, size});
      if (kind != REQ_UNUSED)
         gen_items++;
      if (kind == crtc_pkg::REQ_CLEAR) begin
         gen_lo.delete();
         gen_hi.delete();
      end else if (kind == crtc_pkg::REQ_ADD) begin
         if (gen_hi.size() > 0 && base == gen_hi[$]) begin
            gen_hi[$] = base + size;
         end else if (gen_lo.size() < crtc_pkg::TABLE_DEPTH) begin
            gen_lo.push_back(base);
            gen_hi.push_back(base + size);
         end
      end
   endtask

   task automatic push_query();
      int unsigned        pick;
      int                 i;
      crtc_pkg::addr_type lo;
      crtc_pkg::addr_type len;
      crtc_pkg::addr_type off;
      pick = $urandom_range(0, 9);
      if (gen_lo.size() == 0 || pick == 0) begin
         if ($urandom_range(0, 1))
            push_word(crtc_pkg::REQ_QUERY, rand64(), rand64());
         else
            push_word(crtc_pkg::REQ_QUERY, crtc_pkg::addr_type'($urandom_range(0, 'hffff)),
                      crtc_pkg::addr_type'($urandom_range(0, 'hffff)));
      end else begin
         i   = $urandom_range(0, gen_lo.size() - 1);
         lo  = gen_lo[i];
         len = gen_hi[i] - lo;
         case (pick)
            1, 2, 3, 4: begin
               off = (len == 0) ? '0 : rand64() % len;
               push_word(crtc_pkg::REQ_QUERY, lo + off,
                         (len == 0) ? '0 : rand64() % (len - off));
            end
            5: push_word(crtc_pkg::REQ_QUERY, lo, len);
            6: push_word(crtc_pkg::REQ_QUERY, lo, len + 1);
            7: push_word(crtc_pkg::REQ_QUERY, lo - 1, len);
            8: push_word(crtc_pkg::REQ_QUERY, lo, gen_hi[$] - lo);
            default: push_word(crtc_pkg::REQ_QUERY, gen_hi[$],
                               crtc_pkg::addr_type'($urandom_range(1, 64)));
         endcase
      end
   endtask

   // ascending adds with merges and gaps, queries in between
   task automatic push_run(bit fill);
      int                 n;
      int unsigned        pick;
      crtc_pkg::addr_type cursor;
      crtc_pkg::addr_type base;
      crtc_pkg::addr_type size;
      if ($urandom_range(0, 3) != 0)
         push_word(crtc_pkg::REQ_CLEAR, rand64(), rand64());
      pick = $urandom_range(0, 5);
      if (pick == 0)
         cursor = rand64();
      else if (pick == 1)
         cursor = '1 - crtc_pkg::addr_type'($urandom_range(0, 'h4000));
      else
         cursor = crtc_pkg::addr_type'($urandom_range(0, 1 << 20));
      n = fill ? $urandom_range(60, 72) : $urandom_range(1, 8);
      repeat (n) begin
         base = cursor;
         if ($urandom_range(0, 9) >= 3)
            base = cursor + crtc_pkg::addr_type'($urandom_range(1, 'h1000));
         pick = $urandom_range(0, 19);
         if (pick == 0)
            size = '0;
         else if (pick == 1)
            size = rand64();
         else
            size = crtc_pkg::addr_type'($urandom_range(1, 'h1000));
         push_word(crtc_pkg::REQ_ADD, base, size);
         cursor = base + size;
         if ($urandom_range(0, 9) < 3)
            push_query();
      end
      repeat ($urandom_range(2, 8)) push_query();
   endtask

   task automatic push_noise();
      logic [1:0] kind;
      repeat ($urandom_range(3, 8)) begin
         kind = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 1))
            push_word(kind, rand64(), rand64());
         else
            push_word(kind, crtc_pkg::addr_type'($urandom_range(0, 'hffff)),
                      crtc_pkg::addr_type'($urandom_range(0, 'hffff)));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && !idle_roll(1'b0)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_words[0].kind;
            req_tdata  <= {pending_words[0].size, pending_words[0].base};
            void'(pending_words.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && req_count >= HOLD_START) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_table(req_tuser, req_tdata[63:0],
                                                 req_tdata[127:64]));
            req_count <= req_count + 1;
            if (req_tuser == crtc_pkg::REQ_CLEAR)
               n_clears++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = table_rsp_type'(rsp_tdata);
            n_words++;
            if (got.contained === 1'b1)
               n_hits++;
            if (got.status === crtc_pkg::STAT_MERGED)
               n_merged++;
            if (got.status === crtc_pkg::STAT_DROPPED)
               n_dropped++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: result word with nothing expected, actual %0h", $time,
                        rsp_tdata);
               error_count++;
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (got.contained !== exp_rsp.contained) begin
                  $display("%0t: contained expected %0h actual %0h", $time,
                           exp_rsp.contained, got.contained);
                  error_count++;
               end
               if (got.status !== exp_rsp.status) begin
                  $display("%0t: status expected %0h actual %0h", $time,
                           exp_rsp.status, got.status);
                  error_count++;
               end
               if (got.count !== exp_rsp.count) begin
                  $display("%0t: range_count expected %0d actual %0d", $time,
                           exp_rsp.count, got.count);
                  error_count++;
               end
               if (got.pad !== exp_rsp.pad) begin
                  $display("%0t: padding expected %0h actual %0h", $time,
                           exp_rsp.pad, got.pad);
                  error_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && !idle_roll(1'b1);
      end
   end

   initial begin
      // empty table
      push_word(crtc_pkg::REQ_QUERY, '0, '0);
      push_word(crtc_pkg::REQ_QUERY, '1, '1);
      push_word(REQ_UNUSED, '1, '1);
      // append, merge, hit and near misses
      push_word(crtc_pkg::REQ_ADD, 64'h1000, 64'h100);
      push_word(crtc_pkg::REQ_ADD, 64'h1100, 64'h80);
      push_word(crtc_pkg::REQ_QUERY, 64'h1000, 64'h180);
      push_word(crtc_pkg::REQ_QUERY, 64'h1000, 64'h181);
      push_word(crtc_pkg::REQ_QUERY, 64'hfff, 64'h10);
      // zero size entry grown by a merge, query across the gap
      push_word(crtc_pkg::REQ_ADD, 64'h4000, 64'h0);
      push_word(crtc_pkg::REQ_ADD, 64'h4000, 64'h40);
      push_word(crtc_pkg::REQ_QUERY, 64'h1100, 64'h3000);
      // entry whose end wraps to zero
      push_word(crtc_pkg::REQ_ADD, 64'hffff_ffff_ffff_ff00, 64'h100);
      push_word(crtc_pkg::REQ_QUERY, 64'hffff_ffff_ffff_ff00, 64'h100);
      push_word(crtc_pkg::REQ_QUERY, 64'h1010, 64'h10);
      // merged size wraps
      push_word(crtc_pkg::REQ_ADD, '0, '1);
      push_word(crtc_pkg::REQ_QUERY, '1, '1);
      push_word(crtc_pkg::REQ_CLEAR, '0, '0);
      // adds out of order
      push_word(crtc_pkg::REQ_ADD, 64'h8000, 64'h100);
      push_word(crtc_pkg::REQ_ADD, 64'h2000, 64'h100);
      push_word(crtc_pkg::REQ_QUERY, 64'h2000, 64'h80);
      push_word(crtc_pkg::REQ_QUERY, 64'h8000, 64'h100);
      push_word(crtc_pkg::REQ_CLEAR, '1, '1);

      push_run(1'b1);
      while (gen_items < N_ITEMS) begin
         if ($urandom_range(0, 9) < 7)
            push_run($urandom_range(0, 11) == 0);
         else
            push_noise();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_rsp.size() != 0);
      repeat (crtc_pkg::TABLE_DEPTH + 8) @(negedge clock);

      $display("covered %0d result words, %0d clears, %0d contained queries", n_words,
               n_clears, n_hits);
      $display("adds merged %0d, adds dropped on a full table %0d", n_merged, n_dropped);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
